// ----- sv/sacr_pkg.sv -----
// package for the set-associative cache replacement unit
// holds geometry constants, policy and register codes, the metadata row type and fsm states
package sacr_pkg;

    localparam int MAX_WAYS   = 8;
    localparam int MAX_SETS   = 256;
    localparam int ADDR_WIDTH = 32;
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int LOG_SETS_MAX = SET_W;
    localparam int TAG_ROW_W  = MAX_WAYS * ADDR_WIDTH;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_MRU  = 2'd2;

    localparam logic [1:0] REG_POLICY   = 2'd0;
    localparam logic [1:0] REG_LOG_WAYS = 2'd1;
    localparam logic [1:0] REG_LOG_WPB  = 2'd2;
    localparam logic [1:0] REG_LOG_SETS = 2'd3;

    // per-set replacement state, one memory row
    typedef struct packed {
        logic [MAX_WAYS-1:0]            vld;
        logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
        logic [WAY_W-1:0]               fp;
        logic                           full;
        logic [WAY_W-1:0]               last;
    } meta_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

endpackage

// ----- sv/set_assoc_cache_replacement_unit.sv -----
// an accepted beat starts the registered read of the tag and metadata memories, and the result
// beat is registered at the write-back that follows; no new access is taken before that write-back
// a result beat waiting at the output holds the commit of the next access
// reset restores config defaults, clears totals and one valid flag per set row at once; no clearing pass
// depends on sacr_pkg, sacr_ctrl, sacr_datapath
module set_assoc_cache_replacement_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [2:0]  way_used,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    sacr_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sacr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sacr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .word_address (word_address),
        .hit          (hit),
        .way_used     (way_used),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

endmodule

// ----- sv/sacr_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no package dependency
module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/sacr_ctrl.sv -----
// controller fsm: accepts one access, then commits it once the output register is free
// depends on sacr_pkg
module sacr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sacr_pkg::ctrl_cmd_t cmd
);

    sacr_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sacr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            sacr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sacr_pkg::ST_BUSY;
                end
            end
            sacr_pkg::ST_BUSY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sacr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/sacr_datapath.sv -----
// datapath: config registers, tag and metadata memories, hit check, victim choice, rank update
// depends on sacr_pkg and sacr_ram
module sacr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sacr_pkg::ctrl_cmd_t cmd,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [31:0]         word_address,
    output logic                hit,
    output logic [2:0]          way_used,
    output logic [31:0]         hit_total,
    output logic [31:0]         miss_total
);

    localparam int W  = sacr_pkg::MAX_WAYS;
    localparam int WW = sacr_pkg::WAY_W;
    localparam int SW = sacr_pkg::SET_W;
    localparam int AW = sacr_pkg::ADDR_WIDTH;

    logic [1:0] policy_reg;
    logic [1:0] log_ways_reg;
    logic [2:0] log_wpb_reg;
    logic [3:0] log_sets_reg;

    logic [AW-1:0]  baddr_reg;
    logic [SW-1:0]  set_reg;
    logic           row_ok_reg;
    logic [sacr_pkg::MAX_SETS-1:0] row_valid_reg;
    logic [31:0]    hit_cnt_reg, miss_cnt_reg;
    logic           hit_reg;
    logic [2:0]     way_reg;

    logic [AW-1:0]  baddr_next;
    logic [SW-1:0]  set_next;
    logic [3:0]     ls_clamped;
    logic [SW-1:0]  set_mask;
    logic [WW-1:0]  way_mask;
    logic [W-1:0]   in_use;

    logic [sacr_pkg::TAG_ROW_W-1:0] tag_rd, tag_wr;
    logic [$bits(sacr_pkg::meta_t)-1:0] meta_rd_raw;
    sacr_pkg::meta_t meta_rd, meta_wr;

    logic [W-1:0]  match;
    logic          is_hit;
    logic [WW-1:0] hit_way, lru_way, victim, way_sel;
    logic [WW-1:0] best;
    logic [WW-1:0] fp_new;
    logic          was_valid;
    logic [WW-1:0] old_rank;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= sacr_pkg::POL_FIFO;
            log_ways_reg <= 2'd1;
            log_wpb_reg  <= 3'd2;
            log_sets_reg <= 4'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sacr_pkg::REG_POLICY:   policy_reg   <= cfg_data[1:0];
                sacr_pkg::REG_LOG_WAYS: log_ways_reg <= cfg_data[1:0];
                sacr_pkg::REG_LOG_WPB:  log_wpb_reg  <= cfg_data[2:0];
                sacr_pkg::REG_LOG_SETS: log_sets_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // geometry masks
    always_comb
    begin
        ls_clamped = (log_sets_reg > 4'(sacr_pkg::LOG_SETS_MAX)) ?
                     4'(sacr_pkg::LOG_SETS_MAX) : log_sets_reg;
        set_mask   = SW'(({{SW{1'b0}}, 1'b1} << ls_clamped) - 1'b1);
        way_mask   = WW'(({{WW{1'b0}}, 1'b1} << log_ways_reg) - 1'b1);
        for (int i = 0; i < W; i++)
        begin
            in_use[i] = (WW'(i) & ~way_mask) == '0;
        end
        baddr_next = word_address >> log_wpb_reg;
        set_next   = baddr_next[SW-1:0] & set_mask;
    end

    // access capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            baddr_reg  <= baddr_next;
            set_reg    <= set_next;
            row_ok_reg <= row_valid_reg[set_next];
        end
    end

    sacr_ram #(.WIDTH(sacr_pkg::TAG_ROW_W), .DEPTH(sacr_pkg::MAX_SETS)) u_tag_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (set_reg),
        .wdata (tag_wr),
        .re    (cmd.load),
        .raddr (set_next),
        .rdata (tag_rd)
    );

    sacr_ram #(.WIDTH($bits(sacr_pkg::meta_t)), .DEPTH(sacr_pkg::MAX_SETS)) u_meta_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (set_reg),
        .wdata (meta_wr),
        .re    (cmd.load),
        .raddr (set_next),
        .rdata (meta_rd_raw)
    );

    // the metadata of a row never written since reset reads as all zero
    assign meta_rd = row_ok_reg ? sacr_pkg::meta_t'(meta_rd_raw) : '0;

    // hit check, lowest matching way wins
    always_comb
    begin
        is_hit  = 1'b0;
        hit_way = '0;
        for (int i = 0; i < W; i++)
        begin
            match[i] = in_use[i] && meta_rd.vld[i] && (tag_rd[i*AW +: AW] == baddr_reg);
        end
        for (int i = W - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                is_hit  = 1'b1;
                hit_way = WW'(i);
            end
        end
    end

    // oldest rank among valid ways, ties to the lowest way
    always_comb
    begin
        best    = '0;
        lru_way = '0;
        for (int i = 0; i < W; i++)
        begin
            if (in_use[i] && meta_rd.vld[i] && (i == 0 || meta_rd.rank[i] > best))
            begin
                best    = meta_rd.rank[i];
                lru_way = WW'(i);
            end
        end
    end

    // victim choice and metadata update
    always_comb
    begin
        meta_wr = meta_rd;
        fp_new  = (meta_rd.fp & way_mask) + 1'b1;
        if (policy_reg == sacr_pkg::POL_LRU && meta_rd.full)
        begin
            victim = lru_way;
        end
        else if (policy_reg == sacr_pkg::POL_MRU && meta_rd.full)
        begin
            victim = meta_rd.last & way_mask;
        end
        else
        begin
            victim     = meta_rd.fp & way_mask;
            meta_wr.fp = fp_new & way_mask;
            if ((fp_new & way_mask) == '0)
            begin
                meta_wr.full = 1'b1;
            end
        end
        if (is_hit)
        begin
            meta_wr.fp   = meta_rd.fp;
            meta_wr.full = meta_rd.full;
        end
        way_sel   = is_hit ? hit_way : victim;
        was_valid = meta_rd.vld[way_sel];
        old_rank  = meta_rd.rank[way_sel];
        // recency ranks age behind the used way
        for (int i = 0; i < W; i++)
        begin
            if (in_use[i] && WW'(i) != way_sel && meta_rd.vld[i] &&
                (!was_valid || meta_rd.rank[i] < old_rank) && meta_rd.rank[i] != '1)
            begin
                meta_wr.rank[i] = meta_rd.rank[i] + 1'b1;
            end
        end
        meta_wr.rank[way_sel] = '0;
        meta_wr.vld[way_sel]  = 1'b1;
        meta_wr.last          = way_sel;
        tag_wr                = tag_rd;
        if (!is_hit)
        begin
            tag_wr[way_sel*AW +: AW] = baddr_reg;
        end
    end

    // row valid flags and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            row_valid_reg[set_reg] <= 1'b1;
            if (is_hit)
            begin
                hit_cnt_reg <= hit_cnt_reg + 32'd1;
            end
            else
            begin
                miss_cnt_reg <= miss_cnt_reg + 32'd1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg <= is_hit;
            way_reg <= 3'(way_sel);
        end
    end

    assign hit        = hit_reg;
    assign way_used   = way_reg;
    assign hit_total  = hit_cnt_reg;
    assign miss_total = miss_cnt_reg;

endmodule

// ----- sv/sacr_checker.sv -----
// port-level checks for the replacement unit, bound to the top level
// no package dependency
module sacr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [2:0]  way_used,
    input logic [31:0] hit_total,
    input logic [31:0] miss_total
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way_used)
            && $stable(hit_total) && $stable(miss_total))
        else $error("result beat changed while stalled");

    // one access at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    // a new result only follows an access in flight
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without access");

    // each new result moves exactly one total by one
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid ||
            (hit ? hit_total == $past(hit_total) + 32'd1 && miss_total == $past(miss_total)
                 : miss_total == $past(miss_total) + 32'd1 && hit_total == $past(hit_total)))
        else $error("totals out of step");

endmodule

bind set_assoc_cache_replacement_unit sacr_checker u_sacr_checker (.*);

// ----- tb/set_assoc_cache_replacement_unit_test.sv -----
// testbench for the set-associative cache replacement unit: random and directed address traces
// checked against an in-bench tag/rank predictor; depends on sacr_pkg and the unit's rtl
module set_assoc_cache_replacement_unit_test;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic [31:0] hits;
        logic [31:0] misses;
    } access_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] word_address;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [2:0]  way_used;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    set_assoc_cache_replacement_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .word_address(word_address),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .way_used(way_used),
        .hit_total(hit_total), .miss_total(miss_total),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [1:0]  pr_policy;
    logic [1:0]  pr_log_ways;
    logic [2:0]  pr_log_wpb;
    logic [3:0]  pr_log_sets;
    logic [31:0] pr_tag [sacr_pkg::MAX_SETS*sacr_pkg::MAX_WAYS];
    logic        pr_vld [sacr_pkg::MAX_SETS*sacr_pkg::MAX_WAYS];
    logic [2:0]  pr_rank [sacr_pkg::MAX_SETS*sacr_pkg::MAX_WAYS];
    logic [2:0]  pr_fp [sacr_pkg::MAX_SETS];
    logic        pr_full [sacr_pkg::MAX_SETS];
    logic [2:0]  pr_last [sacr_pkg::MAX_SETS];
    logic [31:0] pr_hits;
    logic [31:0] pr_misses;

    logic [31:0]  addr_queue [$];
    access_rsp_t  expected_rsp [$];
    int           errors;
    int           cycles = 0;
    int           send_idle_pct;
    int           recv_idle_pct;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void predictor_reset();
        pr_policy   = sacr_pkg::POL_FIFO;
        pr_log_ways = 2'd1;
        pr_log_wpb  = 3'd2;
        pr_log_sets = 4'd4;
        for (int i = 0; i < sacr_pkg::MAX_SETS*sacr_pkg::MAX_WAYS; i++)
        begin
            pr_vld[i]  = 1'b0;
            pr_rank[i] = '0;
            pr_tag[i]  = '0;
        end
        for (int s = 0; s < sacr_pkg::MAX_SETS; s++)
        begin
            pr_fp[s]   = '0;
            pr_full[s] = 1'b0;
            pr_last[s] = '0;
        end
        pr_hits   = '0;
        pr_misses = '0;
    endfunction

    function automatic void predictor_config(logic [1:0] idx, logic [31:0] val);
        case (idx)
            sacr_pkg::REG_POLICY:   pr_policy   = val[1:0];
            sacr_pkg::REG_LOG_WAYS: pr_log_ways = val[1:0];
            sacr_pkg::REG_LOG_WPB:  pr_log_wpb  = val[2:0];
            sacr_pkg::REG_LOG_SETS: pr_log_sets = val[3:0];
            default: ;
        endcase
    endfunction

    // one access: lookup, victim pick, rank update, fill
    function automatic access_rsp_t predict_access(logic [31:0] addr);
        access_rsp_t r;
        logic [31:0] baddr;
        int ways;
        int sets;
        int lw;
        int ls;
        int set_i;
        int base;
        int way;
        bit found;
        bit was_valid;
        int old;
        int best;
        baddr = addr >> pr_log_wpb;
        lw = (pr_log_ways > 3) ? 3 : pr_log_ways;
        ls = (pr_log_sets > 8) ? 8 : pr_log_sets;
        ways = 1 << lw;
        sets = 1 << ls;
        set_i = int'(baddr & 32'(sets - 1));
        base = set_i * sacr_pkg::MAX_WAYS;
        way = 0;
        found = 0;
        for (int w = 0; w < ways; w++)
        begin
            if (!found && pr_vld[base+w] && pr_tag[base+w] == baddr)
            begin
                found = 1;
                way = w;
            end
        end
        if (found)
            pr_hits++;
        else
        begin
            pr_misses++;
            if (pr_policy == sacr_pkg::POL_LRU && pr_full[set_i])
            begin
                best = 0;
                way = 0;
                for (int w = 0; w < ways; w++)
                begin
                    if (pr_vld[base+w] && (w == 0 || pr_rank[base+w] > best))
                    begin
                        best = pr_rank[base+w];
                        way = w;
                    end
                end
            end
            else if (pr_policy == sacr_pkg::POL_MRU && pr_full[set_i])
                way = pr_last[set_i] & (ways - 1);
            else
            begin
                way = pr_fp[set_i] & (ways - 1);
                pr_fp[set_i] = 3'((way + 1) & (ways - 1));
                if (pr_fp[set_i] == 0)
                    pr_full[set_i] = 1'b1;
            end
        end
        // recency ranks saturate at the top rank
        was_valid = pr_vld[base+way];
        old = pr_rank[base+way];
        for (int w = 0; w < ways; w++)
        begin
            if (w != way && pr_vld[base+w] && (!was_valid || pr_rank[base+w] < old)
                && pr_rank[base+w] < sacr_pkg::MAX_WAYS-1)
                pr_rank[base+w]++;
        end
        pr_rank[base+way] = '0;
        if (!found)
        begin
            pr_tag[base+way] = baddr;
            pr_vld[base+way] = 1'b1;
        end
        pr_last[set_i] = 3'(way);
        r.hit = found;
        r.way = 3'(way);
        r.hits = pr_hits;
        r.misses = pr_misses;
        return r;
    endfunction

    // driver: one address beat at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            word_address <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (addr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                word_address <= addr_queue[0];
                expected_rsp.push_back(predict_access(addr_queue[0]));
                void'(addr_queue.pop_front());
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    if (hit !== expected_rsp[0].hit)
                    begin
                        $display("%0t: hit expected %0d actual %0d", $time,
                                 expected_rsp[0].hit, hit);
                        errors++;
                    end
                    if (way_used !== expected_rsp[0].way)
                    begin
                        $display("%0t: way_used expected %0d actual %0d", $time,
                                 expected_rsp[0].way, way_used);
                        errors++;
                    end
                    if (hit_total !== expected_rsp[0].hits)
                    begin
                        $display("%0t: hit_total expected %0d actual %0d", $time,
                                 expected_rsp[0].hits, hit_total);
                        errors++;
                    end
                    if (miss_total !== expected_rsp[0].misses)
                    begin
                        $display("%0t: miss_total expected %0d actual %0d", $time,
                                 expected_rsp[0].misses, miss_total);
                        errors++;
                    end
                    void'(expected_rsp.pop_front());
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        predictor_config(idx, val);
    endtask

    task automatic drain();
        while (addr_queue.size() > 0 || expected_rsp.size() > 0 || in_valid)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // mostly addresses from a small working set so sets fill and evict
    task automatic queue_random(int n);
        logic [31:0] pool [16];
        for (int i = 0; i < 16; i++)
            pool[i] = $urandom_range(4095);
        pool[15] = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
                addr_queue.push_back(pool[$urandom_range(15)] + $urandom_range(3));
            else
                addr_queue.push_back($urandom);
        end
    endtask

    task automatic run_phase(logic [1:0] pol, logic [1:0] lw, logic [2:0] lwpb,
                             logic [3:0] ls, int n);
        write_reg(sacr_pkg::REG_POLICY, {30'd0, pol});
        write_reg(sacr_pkg::REG_LOG_WAYS, {30'd0, lw});
        write_reg(sacr_pkg::REG_LOG_WPB, {29'd0, lwpb});
        write_reg(sacr_pkg::REG_LOG_SETS, {28'd0, ls});
        queue_random(n);
        drain();
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 9;
        recv_idle_pct = 65;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        predictor_reset();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: address extremes, reuse hits, set filling under reset geometry
        addr_queue.push_back(32'h0000_0000);
        addr_queue.push_back(32'hFFFF_FFFF);
        addr_queue.push_back(32'h0000_0000);
        addr_queue.push_back(32'h0000_0003);
        addr_queue.push_back(32'h0000_0040);
        addr_queue.push_back(32'h0000_0080);
        addr_queue.push_back(32'h0000_0000);
        addr_queue.push_back(32'hAAAA_AAAA);
        addr_queue.push_back(32'h5555_5555);
        addr_queue.push_back(32'hFFFF_FFFF);
        drain();
        // lru on one set, all ways; mru on all ways, clamped sets; unused code on one way
        run_phase(sacr_pkg::POL_LRU, 2'd3, 3'd0, 4'd0, 25);
        run_phase(sacr_pkg::POL_MRU, 2'd3, 3'd7, 4'd15, 25);
        run_phase(2'd3, 2'd0, 3'd4, 4'd8, 25);

        // random phases, idling profile changes partway
        run_phase(sacr_pkg::POL_FIFO, 2'd2, 3'd1, 4'd2, 150);
        run_phase(sacr_pkg::POL_LRU, 2'd2, 3'd0, 4'd1, 150);
        run_phase(sacr_pkg::POL_MRU, 2'd3, 3'd2, 4'd3, 150);
        send_idle_pct = 65;
        recv_idle_pct = 9;
        run_phase(sacr_pkg::POL_LRU, 2'd3, 3'd4, 4'd0, 150);
        run_phase(sacr_pkg::POL_MRU, 2'd1, 3'd0, 4'd8, 150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(sacr_pkg::POL_FIFO, 2'd3, 3'd3, 4'd2, 100);
        // geometry shrink keeps stored state
        run_phase(sacr_pkg::POL_LRU, 2'd1, 3'd3, 4'd1, 100);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sacr_pkg.sv
sv/sacr_ram.sv
sv/sacr_ctrl.sv
sv/sacr_datapath.sv
sv/set_assoc_cache_replacement_unit.sv
sv/sacr_checker.sv
tb/set_assoc_cache_replacement_unit_test.sv
